// File: rtl/assert_macros.svh
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define NCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// antecedent now, consequent in the following cycle
`define NCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ncc_pkg.sv
package ncc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = 48;
    localparam int RAD_W    = 64;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int DEN_W    = 2 * ROOT_W;
    localparam int ALU_W    = DEN_W + 1;
    localparam int Q_W      = 32;
    localparam int CORR_W   = 16;
    localparam int CNT_W    = 5;
    localparam int EXT_SHIFT = RAD_W - ACC_W;

    localparam logic [CNT_W-1:0] SQRT_FIRST = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_FIRST  = CNT_W'(30);
    localparam logic [Q_W-1:0]   Q_SAT      = Q_W'(64'h8000_0000);
    localparam logic [Q_W-1:0]   POS_LIMIT  = Q_W'(32767);
    localparam logic [Q_W-1:0]   NEG_LIMIT  = Q_W'(32768);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SQRT_A,
        S_SQRT_B,
        S_MUL,
        S_CHECK,
        S_DIV,
        S_DONE
    } ncc_state_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] dot_sum;
        logic [ACC_W-1:0]        energy_first;
        logic [ACC_W-1:0]        energy_second;
        logic                    last_pending;
    } acc_status_t;

endpackage

// File: rtl/normalized_correlation.sv
// a beat is registered and then summed into the accumulators; a tlast beat starts the
// sequencer (no divide if the ratio reaches one; if an energy is zero, no roots either)
// throughput: one beat per cycle within a sequence; after tlast the input stalls
// while one shared 65-bit subtractor runs two 32-step square roots and a 31-step divide
// reset: rst_n clears the accumulators, the sequencer and the output valid at once
`include "assert_macros.svh"

module normalized_correlation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_a, sample_b
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // correlation
    output logic        m_axis_tuser    // degenerate
);
    import ncc_pkg::*;

    acc_status_t         status;
    logic                accept;
    logic                seq_idle;
    logic                res_valid;
    logic                res_take;
    logic [CORR_W-1:0]   res_corr;
    logic                res_degen;

    logic                out_valid_reg, out_valid_next;
    logic [CORR_W-1:0]   corr_reg;
    logic                degen_reg;

    assign s_axis_tready = seq_idle & ~status.last_pending;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign res_take      = res_valid & (~out_valid_reg | m_axis_tready);

    ncc_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .sample_a (s_axis_tdata[SAMPLE_W-1:0]),
        .sample_b (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .last     (s_axis_tlast),
        .clear    (res_take),
        .status   (status)
    );

    ncc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .res_take  (res_take),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_corr  (res_corr),
        .res_degen (res_degen)
    );

    always_comb
    begin
        priority if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            corr_reg  <= res_corr;
            degen_reg <= res_degen;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = corr_reg;
    assign m_axis_tuser  = degen_reg;

    `NCC_ASSERT(a_degen_zero,
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0,
        "degenerate beat with nonzero correlation")
    `NCC_ASSERT_NEXT(a_last_stalls,
        s_axis_tvalid && s_axis_tready && s_axis_tlast,
        !s_axis_tready,
        "input taken right after a last beat")

endmodule

// File: rtl/ncc_sub.sv
module ncc_sub (
    input  logic [ncc_pkg::ALU_W-1:0] op_a,
    input  logic [ncc_pkg::ALU_W-1:0] op_b,
    output logic [ncc_pkg::ALU_W-1:0] diff,
    output logic                      ge
);
    import ncc_pkg::*;

    logic [ALU_W:0] wide;

    always_comb
    begin
        wide = {1'b0, op_a} - {1'b0, op_b};
        diff = wide[ALU_W-1:0];
        ge   = ~wide[ALU_W];
    end

endmodule

// File: rtl/ncc_accum.sv
`include "assert_macros.svh"

module ncc_accum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [ncc_pkg::SAMPLE_W-1:0]  sample_a,
    input  logic [ncc_pkg::SAMPLE_W-1:0]  sample_b,
    input  logic                          last,
    input  logic                          clear,
    output ncc_pkg::acc_status_t          status
);
    import ncc_pkg::*;

    logic                        stage_valid_reg;
    logic signed [SAMPLE_W-1:0]  a_reg;
    logic signed [SAMPLE_W-1:0]  b_reg;
    logic                        last_reg;

    logic signed [ACC_W-1:0]     dot_sum_reg, dot_sum_next;
    logic [ACC_W-1:0]            energy_first_reg, energy_first_next;
    logic [ACC_W-1:0]            energy_second_reg, energy_second_next;

    logic signed [PROD_W-1:0]    prod_ab;
    logic signed [PROD_W-1:0]    prod_aa;
    logic signed [PROD_W-1:0]    prod_bb;
    logic signed [ACC_W:0]       dot_wide;
    logic [ACC_W:0]              ea_wide;
    logic [ACC_W:0]              eb_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg    <= sample_a;
            b_reg    <= sample_b;
            last_reg <= last;
        end
    end

    always_comb
    begin
        prod_ab  = a_reg * b_reg;
        prod_aa  = a_reg * a_reg;
        prod_bb  = b_reg * b_reg;
        dot_wide = (ACC_W+1)'(dot_sum_reg) + (ACC_W+1)'(prod_ab);
        ea_wide  = {1'b0, energy_first_reg} + (ACC_W+1)'($unsigned(prod_aa));
        eb_wide  = {1'b0, energy_second_reg} + (ACC_W+1)'($unsigned(prod_bb));

        dot_sum_next       = dot_sum_reg;
        energy_first_next  = energy_first_reg;
        energy_second_next = energy_second_reg;

        priority if (clear)
        begin
            dot_sum_next       = '0;
            energy_first_next  = '0;
            energy_second_next = '0;
        end
        else if (stage_valid_reg)
        begin
            // saturate at the 48-bit range
            if (dot_wide[ACC_W] != dot_wide[ACC_W-1])
            begin
                dot_sum_next = dot_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                               : {1'b0, {(ACC_W-1){1'b1}}};
            end
            else
            begin
                dot_sum_next = dot_wide[ACC_W-1:0];
            end
            energy_first_next  = ea_wide[ACC_W] ? '1 : ea_wide[ACC_W-1:0];
            energy_second_next = eb_wide[ACC_W] ? '1 : eb_wide[ACC_W-1:0];
        end
        else
        begin
            dot_sum_next       = dot_sum_reg;
            energy_first_next  = energy_first_reg;
            energy_second_next = energy_second_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_sum_reg       <= '0;
            energy_first_reg  <= '0;
            energy_second_reg <= '0;
        end
        else
        begin
            dot_sum_reg       <= dot_sum_next;
            energy_first_reg  <= energy_first_next;
            energy_second_reg <= energy_second_next;
        end
    end

    assign status.dot_sum       = dot_sum_reg;
    assign status.energy_first  = energy_first_reg;
    assign status.energy_second = energy_second_reg;
    assign status.last_pending  = stage_valid_reg & last_reg;

    `NCC_ASSERT(a_zero_energy_zero_dot,
        (energy_first_reg == '0 || energy_second_reg == '0) |-> dot_sum_reg == '0,
        "dot product nonzero with a silent sequence")

endmodule

// File: rtl/ncc_seq.sv
`include "assert_macros.svh"

module ncc_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ncc_pkg::acc_status_t           status,
    input  logic                           res_take,
    output logic                           idle,
    output logic                           res_valid,
    output logic [ncc_pkg::CORR_W-1:0]     res_corr,
    output logic                           res_degen
);
    import ncc_pkg::*;

    ncc_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RAD_W-1:0]    x_reg, x_next;
    logic [RAD_W-1:0]    res_reg, res_next;
    logic [ROOT_W-1:0]   ra_reg, ra_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [Q_W-1:0]      q_reg, q_next;
    logic                degen_reg, degen_next;

    logic [RAD_W-1:0]    sq_bit;
    logic [RAD_W-1:0]    sq_trial;
    logic [ACC_W-1:0]    mag;
    logic [ALU_W-1:0]    op_a, op_b, diff;
    logic                ge;
    logic [Q_W-1:0]      q_clamp;
    logic [CORR_W-1:0]   corr;

    ncc_sub u_sub (
        .op_a (op_a),
        .op_b (op_b),
        .diff (diff),
        .ge   (ge)
    );

    always_comb
    begin
        sq_bit   = RAD_W'(1) << {cnt_reg, 1'b0};
        sq_trial = res_reg | sq_bit;
        mag      = status.dot_sum[ACC_W-1] ? ACC_W'(-status.dot_sum)
                                           : ACC_W'(status.dot_sum);

        unique case (state_reg)
            S_SQRT_A, S_SQRT_B:
            begin
                op_a = {1'b0, x_reg};
                op_b = {1'b0, sq_trial};
            end
            S_CHECK:
            begin
                op_a = {1'b0, x_reg};
                op_b = {1'b0, den_reg};
            end
            S_DIV:
            begin
                op_a = {x_reg, 1'b0};
                op_b = {1'b0, den_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase

        if (status.dot_sum[ACC_W-1])
        begin
            q_clamp = (q_reg > NEG_LIMIT) ? NEG_LIMIT : q_reg;
            corr    = CORR_W'(-q_clamp);
        end
        else
        begin
            q_clamp = (q_reg > POS_LIMIT) ? POS_LIMIT : q_reg;
            corr    = q_clamp[CORR_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        res_next   = res_reg;
        ra_next    = ra_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        degen_next = degen_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (status.last_pending)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                x_next   = {status.energy_first, EXT_SHIFT'(0)};
                res_next = '0;
                cnt_next = SQRT_FIRST;
                q_next   = '0;
                if (status.energy_first == '0 || status.energy_second == '0)
                begin
                    degen_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    degen_next = 1'b0;
                    state_next = S_SQRT_A;
                end
            end
            S_SQRT_A, S_SQRT_B:
            begin
                if (ge)
                begin
                    x_next   = diff[RAD_W-1:0];
                    res_next = (res_reg >> 1) | sq_bit;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (state_reg == S_SQRT_A)
                    begin
                        ra_next    = res_next[ROOT_W-1:0];
                        x_next     = {status.energy_second, EXT_SHIFT'(0)};
                        res_next   = '0;
                        cnt_next   = SQRT_FIRST;
                        state_next = S_SQRT_B;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                den_next   = ra_reg * res_reg[ROOT_W-1:0];
                x_next     = RAD_W'(mag);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (ge)
                begin
                    q_next     = Q_SAT;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next   = DIV_FIRST;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (ge)
                begin
                    x_next = diff[RAD_W-1:0];
                    q_next = {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    x_next = op_a[RAD_W-1:0];
                    q_next = {q_reg[Q_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        x_reg     <= x_next;
        res_reg   <= res_next;
        ra_reg    <= ra_next;
        den_reg   <= den_next;
        q_reg     <= q_next;
        degen_reg <= degen_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_corr  = degen_reg ? '0 : corr;
    assign res_degen = degen_reg;

    `NCC_ASSERT(a_div_nonzero_den,
        (state_reg == S_CHECK || state_reg == S_DIV) |-> den_reg != '0,
        "divide with zero denominator")
    `NCC_ASSERT(a_quot_in_range,
        state_reg == S_DIV |-> q_reg[Q_W-1] == 1'b0,
        "quotient overflow during division")

endmodule

// File: bench/correlation_checker.sv
module correlation_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,
    input  logic                         s_axis_tlast,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [ncc_pkg::CORR_W-1:0]   m_axis_tdata,
    input  logic                         m_axis_tuser,
    output int                           mismatches,
    output int                           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import ncc_pkg::*;

    localparam logic signed [63:0] DOT_HI     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] DOT_LO     = -DOT_HI - 64'sd1;
    localparam logic [63:0]        ENERGY_CAP = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [CORR_W-1:0] corr;
        logic                     degen;
    } coeff_t;

    coeff_t                   pending_coeffs[$];
    logic signed [ACC_W-1:0]  dot_acc;
    logic [ACC_W-1:0]         energy_a_acc;
    logic [ACC_W-1:0]         energy_b_acc;

    function automatic logic [63:0] int_sqrt(input logic [63:0] radicand);
        logic [63:0] x;
        logic [63:0] root;
        logic [63:0] place;
        x = radicand;
        root = '0;
        place = 64'h4000_0000_0000_0000;
        while (place > x)
            place = place >> 2;
        while (place != 0)
        begin
            if (x >= root + place)
            begin
                x = x - (root + place);
                root = (root >> 1) + place;
            end
            else
            begin
                root = root >> 1;
            end
            place = place >> 2;
        end
        return root;
    endfunction

    // floor(num * 2^31 / den), saturated to 2^31
    function automatic logic [31:0] scaled_ratio(input logic [63:0] num,
                                                 input logic [63:0] den);
        logic [63:0] rem;
        logic [31:0] q;
        logic        carry;
        if (num >= den)
            return 32'h8000_0000;
        rem = num;
        q = '0;
        for (int i = 0; i < 31; i++)
        begin
            carry = rem[63];
            rem = rem << 1;
            q = q << 1;
            if (carry || rem >= den)
            begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic coeff_t coefficient_of(input logic signed [ACC_W-1:0] dot,
                                              input logic [ACC_W-1:0] ea,
                                              input logic [ACC_W-1:0] eb);
        coeff_t      c;
        logic [63:0] ra;
        logic [63:0] rb;
        logic [63:0] den;
        logic [63:0] mag;
        logic [31:0] q;
        c.corr = '0;
        c.degen = 1'b0;
        if (ea == '0 || eb == '0)
        begin
            c.degen = 1'b1;
            return c;
        end
        ra = int_sqrt({ea, 16'b0});
        rb = int_sqrt({eb, 16'b0});
        den = ra * rb;
        mag = dot[ACC_W-1] ? -{{(64-ACC_W){1'b1}}, dot} : {{(64-ACC_W){1'b0}}, dot};
        q = scaled_ratio(mag, den);
        if (dot[ACC_W-1])
        begin
            if (q > NEG_LIMIT)
                q = NEG_LIMIT;
            c.corr = -q[CORR_W-1:0];
        end
        else
        begin
            if (q > POS_LIMIT)
                q = POS_LIMIT;
            c.corr = q[CORR_W-1:0];
        end
        return c;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic absorb_pair(input logic [31:0] data, input logic last);
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        logic signed [31:0]         ab;
        logic signed [31:0]         aa;
        logic signed [31:0]         bb;
        logic signed [63:0]         dot_next;
        logic [63:0]                ea_next;
        logic [63:0]                eb_next;
        a = data[15:0];
        b = data[31:16];
        ab = a * b;
        aa = a * a;
        bb = b * b;
        dot_next = dot_acc + ab;
        if (dot_next > DOT_HI)
            dot_next = DOT_HI;
        else if (dot_next < DOT_LO)
            dot_next = DOT_LO;
        dot_acc = dot_next[ACC_W-1:0];
        ea_next = {16'b0, energy_a_acc} + {32'b0, aa};
        eb_next = {16'b0, energy_b_acc} + {32'b0, bb};
        energy_a_acc = (ea_next > ENERGY_CAP) ? ENERGY_CAP[ACC_W-1:0] : ea_next[ACC_W-1:0];
        energy_b_acc = (eb_next > ENERGY_CAP) ? ENERGY_CAP[ACC_W-1:0] : eb_next[ACC_W-1:0];
        if (last)
        begin
            pending_coeffs.push_back(coefficient_of(dot_acc, energy_a_acc, energy_b_acc));
            dot_acc = '0;
            energy_a_acc = '0;
            energy_b_acc = '0;
        end
    endtask

    task automatic check_result();
        coeff_t want;
        if (pending_coeffs.size() == 0)
        begin
            flag_mismatch($sformatf("result beat with nothing expected, correlation %0d",
                                    $signed(m_axis_tdata)));
            return;
        end
        want = pending_coeffs.pop_front();
        if (m_axis_tdata !== want.corr)
            flag_mismatch($sformatf("correlation got %0d want %0d",
                                    $signed(m_axis_tdata), want.corr));
        if (m_axis_tuser !== want.degen)
            flag_mismatch($sformatf("degenerate got %b want %b", m_axis_tuser, want.degen));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_acc = '0;
            energy_a_acc = '0;
            energy_b_acc = '0;
            pending_coeffs.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                absorb_pair(s_axis_tdata, s_axis_tlast);
            outstanding <= pending_coeffs.size();
        end
    end

endmodule

// File: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 200;

    typedef enum int {
        INDEPENDENT,
        MATCHED,
        OPPOSED,
        NOISY,
        SILENT_A,
        SILENT_B,
        EXTREME
    } run_style_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;     // sample_a, sample_b
    logic        s_axis_tlast;     // last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;     // correlation
    logic        m_axis_tuser;     // degenerate
    logic        calm = 1'b0;
    int          mismatches;
    int          outstanding;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    normalized_correlation uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    correlation_checker monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 19);

    function automatic logic [15:0] any_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
        if (!calm && $urandom_range(0, 99) < 19)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a};
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_run(input int len, input run_style_t style);
        logic [15:0] a;
        logic [15:0] b;
        for (int i = 0; i < len; i++)
        begin
            a = any_sample();
            case (style)
                MATCHED:  b = a;
                OPPOSED:  b = -a;
                NOISY:    b = a + 16'($urandom_range(0, 15)) - 16'd8;
                SILENT_A:
                begin
                    b = a;
                    a = 16'h0000;
                end
                SILENT_B: b = 16'h0000;
                EXTREME:
                begin
                    a = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    b = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                end
                default:  b = any_sample();
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    initial
    begin
        int         items_sent;
        int         len;
        int         pick;
        run_style_t style;

        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single pairs and short runs at the extremes, zero energy on either side, exact minus one
        send_pair(16'h7FFF, 16'h7FFF, 1'b1);
        send_pair(16'h8000, 16'h8000, 1'b1);
        send_pair(16'h7FFF, 16'h8000, 1'b1);
        send_pair(16'h8000, 16'h7FFF, 1'b1);
        send_pair(16'h0000, 16'h04D2, 1'b1);
        send_pair(16'h0005, 16'h0000, 1'b1);
        send_pair(16'h0000, 16'h0000, 1'b1);
        send_pair(16'hFFFF, 16'h0001, 1'b1);
        send_pair(16'h0001, 16'h0001, 1'b0);
        send_pair(16'h0001, 16'hFFFF, 1'b1);
        send_pair(16'h0000, 16'h0005, 1'b0);
        send_pair(16'h0007, 16'h0000, 1'b1);
        send_pair(16'h4000, 16'h4000, 1'b0);
        send_pair(16'hC000, 16'h4000, 1'b0);
        send_pair(16'h7FFF, 16'h0001, 1'b1);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            calm <= (items_sent >= 250 && items_sent < 370);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(1, 16);
            else if (pick < 95)
                len = $urandom_range(17, 64);
            else
                len = $urandom_range(65, 200);
            style = run_style_t'($urandom_range(0, EXTREME));
            send_run(len, style);
            items_sent += len;
        end
        calm <= 1'b0;

        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("normalized_correlation verification clean");
        else
            $display("normalized_correlation verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("normalized_correlation verification failed");
        $finish;
    end

endmodule
